// ===== hdl/tcb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tonal colour balance block: fixed-point constants, register
// indexes, the divider input bundle and the mask ramp function. No dependencies.
package tcb_pkg;

	localparam int PIX_W     = 16;
	localparam int LSUM_W    = 17;
	localparam int MASK_W    = 18;
	localparam int NUM_W     = 36;
	localparam int DV_W      = 18;
	localparam int CORR_W    = 48;
	localparam int ONE17     = 131072;
	localparam int HALF17    = 65536;
	localparam int LOW_EDGE  = 43647;
	localparam int HIGH_EDGE = 87425;
	localparam int SCALE16   = 45875;
	localparam int DIV_STEPS = 16;

	localparam logic [1:0] CFG_RED   = 2'd0;
	localparam logic [1:0] CFG_GREEN = 2'd1;
	localparam logic [1:0] CFG_BLUE  = 2'd2;
	localparam logic [1:0] CFG_KEEP  = 2'd3;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DV_W-1:0]  dv;
		logic [PIX_W-1:0] alt;
		logic             use_alt;
	} tcb_div_in_t;

	// Clamp a ramp value to the range 0 .. 1.0 in Q0.17.
	function automatic logic [MASK_W-1:0] ramp(input logic signed [22:0] x);
		logic [MASK_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > 23'sd131072) begin
			r = MASK_W'(ONE17);
		end else begin
			r = x[MASK_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/tonal_color_balance.sv =====
`timescale 1ns / 1ps
// Tonal colour balance top level: configuration registers, pipeline control
// and stream ports. Depends on tcb_pkg, tcb_balance, tcb_restore, tcb_divider.
//
// The block applies shadow, midtone and highlight colour corrections to one
// RGBA pixel per clock while the output side is ready; a new word may follow
// in every cycle unless the output stalls. Each word passes through the four
// balance stages, the three lightness restore stages and the seventeen stages
// of the restoring divider: a set-up stage with the saturation check, then
// one quotient bit per stage. Every stage has its own valid bit and moves
// on whenever the stage ahead of it is empty or moving, so bubbles close up
// and a stalled output loses nothing. The divider stages are passed through
// even when lightness is not kept, so every word takes the same path.
// Corrections and the lightness flag should only be written while no pixel
// is in flight.
module tonal_color_balance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // red_in, green_in, blue_in, alpha_in
	input  logic        s_tlast,  // run_end_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // red_out, green_out, blue_out, alpha_out
	output logic        m_tlast,  // run_end_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [47:0] cfg_data
);
	import tcb_pkg::*;

	localparam int NSTAGE = 7 + DIV_STEPS + 1;

	// Configuration registers, written one at a time.
	logic [2:0][CORR_W-1:0] corr_q;
	logic                   keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q <= '0;
			keep_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RED:   corr_q[0] <= cfg_data;
				CFG_GREEN: corr_q[1] <= cfg_data;
				CFG_BLUE:  corr_q[2] <= cfg_data;
				CFG_KEEP:  keep_q    <= cfg_data[0];
				default:   keep_q    <= keep_q;
			endcase
		end
	end

	// Stage enables: a stage may load when it is empty or when the stage
	// after it loads in the same cycle. The last stage is the output register.
	logic [NSTAGE:1]   valid_q;
	logic [NSTAGE+1:1] en;

	always_comb begin
		en[NSTAGE+1] = m_tready;
		for (int k = NSTAGE; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) valid_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	// Alpha and the run end marker ride alongside the colour channels.
	logic [PIX_W-1:0] alpha_q [1:NSTAGE];
	logic             last_q  [1:NSTAGE];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			alpha_q[1] <= s_tdata[63:48];
			last_q[1]  <= s_tlast;
		end
		for (int k = 2; k <= NSTAGE; k++) begin
			if (en[k]) begin
				alpha_q[k] <= alpha_q[k-1];
				last_q[k]  <= last_q[k-1];
			end
		end
	end

	logic [2:0][PIX_W-1:0] chan_in;
	logic [2:0][PIX_W-1:0] chan_s4;
	logic [LSUM_W-1:0]     lsum_s4;
	tcb_div_in_t [2:0]     div_s7;
	logic [2:0][PIX_W-1:0] res;

	assign chan_in = s_tdata[47:0];

	tcb_balance u_balance (
		.clk     (clk),
		.en      (en[4:1]),
		.chan_in (chan_in),
		.corr    (corr_q),
		.chan_s4 (chan_s4),
		.lsum_s4 (lsum_s4)
	);

	tcb_restore u_restore (
		.clk     (clk),
		.en      (en[7:5]),
		.keep    (keep_q),
		.chan_in (chan_s4),
		.lsum_in (lsum_s4),
		.div_s7  (div_s7)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		tcb_divider u_div (
			.clk (clk),
			.en  (en[NSTAGE:8]),
			.din (div_s7[i]),
			.res (res[i])
		);
	end

	assign s_tready = en[1];
	assign m_tvalid = valid_q[NSTAGE];
	assign m_tdata  = {alpha_q[NSTAGE], res[2], res[1], res[0]};
	assign m_tlast  = last_q[NSTAGE];

	// An empty first stage must always be able to take a word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[1] |-> s_tready)
		else $error("input stalled with an empty first stage");

	// With the output side ready the whole pipeline moves, so input is open.
	a_flow_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the output was ready");

	// An accepted word must occupy the first stage on the next cycle.
	a_word_captured: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_q[1])
		else $error("accepted word lost at the first stage");

endmodule

// ===== hdl/tcb_balance.sv =====
`timescale 1ns / 1ps
// Lightness, tonal masks and weighted corrections, four pipeline stages.
// Depends on tcb_pkg.
module tcb_balance (
	input  logic                                 clk,
	input  logic [3:0]                           en,
	input  logic [2:0][tcb_pkg::PIX_W-1:0]       chan_in,
	input  logic [2:0][tcb_pkg::CORR_W-1:0]      corr,
	output logic [2:0][tcb_pkg::PIX_W-1:0]       chan_s4,
	output logic [tcb_pkg::LSUM_W-1:0]           lsum_s4
);
	import tcb_pkg::*;

	logic [PIX_W-1:0]  mx, mn;
	logic [2:0][PIX_W-1:0] c_s1, c_s2, c_s3;
	logic [LSUM_W-1:0] lsum_s1, lsum_s2, lsum_s3;
	logic signed [22:0] dl, dh;
	logic [MASK_W-1:0] ms, lo, hd, mh, mm;
	logic signed [36:0] t_s2 [3];
	logic signed [53:0] prod_s3 [3];

	always_comb begin
		mx = chan_in[0];
		mn = chan_in[0];
		for (int i = 1; i < 3; i++) begin
			if (chan_in[i] > mx) mx = chan_in[i];
			if (chan_in[i] < mn) mn = chan_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s1    <= chan_in;
			lsum_s1 <= LSUM_W'({1'b0, mx} + {1'b0, mn});
		end
	end

	// The midtone mask is the product of two ramps that never overlap, so it
	// reduces to the smaller of the two.
	always_comb begin
		dl = ($signed({6'd0, lsum_s1}) - 23'sd43647) <<< 2;
		dh = ($signed({6'd0, lsum_s1}) - 23'sd87425) <<< 2;
		ms = ramp(23'sd65536 - dl);
		lo = ramp(23'sd65536 + dl);
		hd = ramp(23'sd65536 - dh);
		mh = ramp(23'sd65536 + dh);
		mm = (lo < hd) ? lo : hd;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			c_s2    <= c_s1;
			lsum_s2 <= lsum_s1;
			for (int i = 0; i < 3; i++) begin
				t_s2[i] <= 37'($signed(corr[i][15:0])  * $signed({1'b0, ms}))
				         + 37'($signed(corr[i][31:16]) * $signed({1'b0, mm}))
				         + 37'($signed(corr[i][47:32]) * $signed({1'b0, mh}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			c_s3    <= c_s2;
			lsum_s3 <= lsum_s2;
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= 54'(t_s2[i] * $signed({1'b0, 16'(SCALE16)}));
			end
		end
	end

	logic signed [54:0] acc [3];
	logic signed [54:0] rnd [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = $signed({7'd0, c_s3[i], 32'd0}) + 55'(prod_s3[i]);
			rnd[i] = acc[i] + 55'sd2147483648;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lsum_s4 <= lsum_s3;
			for (int i = 0; i < 3; i++) begin
				if (acc[i] < 0) begin
					chan_s4[i] <= '0;
				end else if (rnd[i][54:48] != '0) begin
					chan_s4[i] <= '1;
				end else begin
					chan_s4[i] <= rnd[i][47:32];
				end
			end
		end
	end

endmodule

// ===== hdl/tcb_restore.sv =====
`timescale 1ns / 1ps
// Lightness restore set-up: spans, cross products and divider operands,
// three pipeline stages. Depends on tcb_pkg.
module tcb_restore (
	input  logic                              clk,
	input  logic [2:0]                        en,
	input  logic                              keep,
	input  logic [2:0][tcb_pkg::PIX_W-1:0]    chan_in,
	input  logic [tcb_pkg::LSUM_W-1:0]        lsum_in,
	output tcb_pkg::tcb_div_in_t [2:0]        div_s7
);
	import tcb_pkg::*;

	logic [PIX_W-1:0]  mx, mn;
	logic [LSUM_W-1:0] sc;
	logic [MASK_W-1:0] sc_rest, ls_rest;
	logic [LSUM_W-1:0] dc, dl;

	logic [2:0][PIX_W-1:0] c_s5;
	logic [LSUM_W-1:0] lsum_s5, sc_s5, dc_s5, d_s5;
	logic gray_s5, keep_s5;

	always_comb begin
		mx = chan_in[0];
		mn = chan_in[0];
		for (int i = 1; i < 3; i++) begin
			if (chan_in[i] > mx) mx = chan_in[i];
			if (chan_in[i] < mn) mn = chan_in[i];
		end
		sc      = LSUM_W'({1'b0, mx} + {1'b0, mn});
		sc_rest = MASK_W'(ONE17) - {1'b0, sc};
		ls_rest = MASK_W'(ONE17) - {1'b0, lsum_in};
		dc      = ({1'b0, sc} < sc_rest) ? sc : sc_rest[LSUM_W-1:0];
		dl      = ({1'b0, lsum_in} < ls_rest) ? lsum_in : ls_rest[LSUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s5    <= chan_in;
			lsum_s5 <= lsum_in;
			sc_s5   <= sc;
			dc_s5   <= dc;
			d_s5    <= dl;
			gray_s5 <= (mx == mn) || (dc == '0);
			keep_s5 <= keep;
		end
	end

	logic [33:0] p1_s6;
	logic signed [36:0] p2_s6 [3];
	logic [2:0][PIX_W-1:0] alt_s6;
	logic [LSUM_W-1:0] dc_s6;
	logic use_alt_s6;
	logic [LSUM_W:0] half_l;
	logic signed [18:0] diff [3];

	always_comb begin
		half_l = {1'b0, lsum_s5} + 18'd1;
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({2'b0, c_s5[i], 1'b0}) - $signed({2'b0, sc_s5});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p1_s6      <= 34'(lsum_s5 * dc_s5);
			dc_s6      <= dc_s5;
			use_alt_s6 <= !keep_s5 || gray_s5;
			for (int i = 0; i < 3; i++) begin
				p2_s6[i]  <= 37'(diff[i] * $signed({1'b0, d_s5}));
				alt_s6[i] <= keep_s5 ? half_l[PIX_W:1] : c_s5[i];
			end
		end
	end

	logic signed [37:0] num [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = $signed({4'd0, p1_s6}) + 38'(p2_s6[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				div_s7[i].num     <= (num[i] < 0) ? NUM_W'(dc_s6)
				                                  : num[i][NUM_W-1:0] + NUM_W'(dc_s6);
				div_s7[i].dv      <= {dc_s6, 1'b0};
				div_s7[i].alt     <= alt_s6[i];
				div_s7[i].use_alt <= use_alt_s6;
			end
		end
	end

endmodule

// ===== hdl/tcb_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, a set-up stage and then one quotient bit per
// stage, with saturation to full scale and a bypass value. Depends on tcb_pkg.
module tcb_divider (
	input  logic                         clk,
	input  logic [tcb_pkg::DIV_STEPS:0]  en,
	input  tcb_pkg::tcb_div_in_t         din,
	output logic [tcb_pkg::PIX_W-1:0]    res
);
	import tcb_pkg::*;

	logic [NUM_W-1:0] rem_p [0:DIV_STEPS];
	logic [DV_W-1:0]  dv_p  [0:DIV_STEPS];
	logic [PIX_W-1:0] alt_p [0:DIV_STEPS];
	logic [PIX_W-1:0] q_p   [0:DIV_STEPS];
	logic             sat_p [0:DIV_STEPS];
	logic             use_p [0:DIV_STEPS];

	// A quotient of 65536 or more saturates; the check lets the bit stages
	// assume the quotient fits in sixteen bits.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_p[0] <= din.num;
			dv_p[0]  <= din.dv;
			alt_p[0] <= din.alt;
			use_p[0] <= din.use_alt;
			q_p[0]   <= '0;
			sat_p[0] <= din.num >= (NUM_W'(din.dv) << PIX_W);
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		localparam int K = DIV_STEPS - j;
		logic [NUM_W-1:0] shifted;
		logic             ge;
		assign shifted = NUM_W'(dv_p[j-1]) << K;
		assign ge      = rem_p[j-1] >= shifted;
		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_p[j] <= ge ? rem_p[j-1] - shifted : rem_p[j-1];
				q_p[j]   <= q_p[j-1] | (PIX_W'(ge) << K);
				dv_p[j]  <= dv_p[j-1];
				alt_p[j] <= alt_p[j-1];
				use_p[j] <= use_p[j-1];
				sat_p[j] <= sat_p[j-1];
			end
		end
	end

	assign res = use_p[DIV_STEPS] ? alt_p[DIV_STEPS]
	           : (sat_p[DIV_STEPS] ? '1 : q_p[DIV_STEPS]);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tonal_color_balance: stream driver, receiver and
// a colour balance predictor. Depends on tcb_pkg and the tonal_color_balance RTL.
module tb_top;
	import tcb_pkg::*;

	// One pixel word as it travels on either stream.
	typedef struct packed {
		logic        last;
		logic [15:0] alpha;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // red_in, green_in, blue_in, alpha_in
	logic        s_tlast;  // run_end_in
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;  // red_out, green_out, blue_out, alpha_out
	logic        m_tlast;  // run_end_out
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [47:0] cfg_data;

	tonal_color_balance dut (.*);

	// Shadow copy of the correction registers, updated as they are written.
	logic [47:0] red_corr, green_corr, blue_corr;
	logic        keep_light;

	pixel_t pending_pixels[$];
	pixel_t expected_pixels[$];
	int     sender_idle_pct;
	int     receiver_idle_pct;
	bit     any_failure;
	bit     word_taken;
	int     cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp a Q0.17 mask ramp to the range 0 .. 1.0.
	function automatic longint clamp_ramp(longint x);
		if (x < 0) return 0;
		if (x > ONE17) return ONE17;
		return x;
	endfunction

	function automatic longint sign16(logic [15:0] v);
		return longint'(signed'(v));
	endfunction

	// One channel: weight the three corrections by the tonal masks, scale by
	// 0.7, add to the input in units of 2^-48, round half up and clamp.
	function automatic longint balance_channel(longint value, longint lsum,
			logic [47:0] corr);
		longint shadow_m, lo_ramp, hi_ramp, high_m, mid_m, acc;
		shadow_m = clamp_ramp(HALF17 - 4 * (lsum - LOW_EDGE));
		lo_ramp  = clamp_ramp(HALF17 + 4 * (lsum - LOW_EDGE));
		hi_ramp  = clamp_ramp(HALF17 - 4 * (lsum - HIGH_EDGE));
		high_m   = clamp_ramp(HALF17 + 4 * (lsum - HIGH_EDGE));
		mid_m    = (lo_ramp * hi_ramp) >>> 17;
		acc = value <<< 32;
		acc += sign16(corr[15:0]) * shadow_m * SCALE16;
		acc += sign16(corr[31:16]) * mid_m * SCALE16;
		acc += sign16(corr[47:32]) * high_m * SCALE16;
		if (acc < 0) return 0;
		acc = (acc + (longint'(1) <<< 31)) >>> 32;
		return (acc > 65535) ? 65535 : acc;
	endfunction

	// Half the HSL chroma span, min(S, 2 - S) in Q1.16.
	function automatic longint chroma_span(longint lsum);
		return (lsum < ONE17 - lsum) ? lsum : ONE17 - lsum;
	endfunction

	function automatic pixel_t predict_balanced(pixel_t px);
		longint ch[3];
		longint mx, mn, lsum, csum, span_in, span_out, num, r;
		pixel_t res;
		ch[0] = px.red; ch[1] = px.green; ch[2] = px.blue;
		mx = ch[0]; mn = ch[0];
		for (int i = 1; i < 3; i++) begin
			if (ch[i] > mx) mx = ch[i];
			if (ch[i] < mn) mn = ch[i];
		end
		lsum = mx + mn;
		ch[0] = balance_channel(ch[0], lsum, red_corr);
		ch[1] = balance_channel(ch[1], lsum, green_corr);
		ch[2] = balance_channel(ch[2], lsum, blue_corr);
		if (keep_light) begin
			mx = ch[0]; mn = ch[0];
			for (int i = 1; i < 3; i++) begin
				if (ch[i] > mx) mx = ch[i];
				if (ch[i] < mn) mn = ch[i];
			end
			csum = mx + mn;
			span_out = chroma_span(csum);
			span_in = chroma_span(lsum);
			for (int i = 0; i < 3; i++) begin
				// A grey corrected pixel simply takes the input lightness.
				if (mx == mn || span_out <= 0) begin
					r = (lsum + 1) >>> 1;
				end else begin
					num = lsum * span_out + (2 * ch[i] - csum) * span_in;
					if (num < 0) num = 0;
					r = (num + span_out) / (2 * span_out);
				end
				if (r > 65535) r = 65535;
				if (r < 0) r = 0;
				ch[i] = r;
			end
		end
		res.red   = ch[0][15:0];
		res.green = ch[1][15:0];
		res.blue  = ch[2][15:0];
		res.alpha = px.alpha;
		res.last  = px.last;
		return res;
	endfunction

	// Register writes happen at the falling edge, and each write strobe is dropped before the next write starts.
	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RED:   red_corr   = val;
			CFG_GREEN: green_corr = val;
			CFG_BLUE:  blue_corr  = val;
			CFG_KEEP:  keep_light = val[0];
		endcase
	endtask

	task automatic add_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] a, logic l);
		pixel_t px;
		px = '{last: l, alpha: a, blue: b, green: g, red: r};
		pending_pixels.push_back(px);
	endtask

	function automatic logic [15:0] rand_corr();
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random pixels: mostly uniform, some grey, some with red at zero or full scale,
	// some with lightness close to a mask ramp so the blend region is well exercised.
	task automatic add_random_pixels(int count);
		logic [15:0] base, r, g, b;
		for (int n = 0; n < count; n++) begin
			r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
			case ($urandom_range(9))
				0: begin
					g = r; b = r;
				end
				1, 2: begin
					base = ($urandom_range(1)) ? 16'd21823 : 16'd43712;
					r = base + 16'($urandom_range(16000)) - 16'd8000;
					g = base + 16'($urandom_range(16000)) - 16'd8000;
					b = base + 16'($urandom_range(16000)) - 16'd8000;
				end
				3: begin
					r = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
				end
				default: ;
			endcase
			add_pixel(r, g, b, 16'($urandom), 1'($urandom));
		end
	endtask

	// Let the queued pixels drain, then allow for the pipeline depth.
	task automatic drain();
		while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Driver: a word leaves s_tvalid high until it is taken.
	always @(negedge clk) begin
		if (!s_tvalid || word_taken) begin
			if (pending_pixels.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				pixel_t px;
				px = pending_pixels.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {px.alpha, px.blue, px.green, px.red};
				s_tlast  <= px.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Monitor: predict on every accepted input word, check every output word.
	always @(posedge clk) begin
		word_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			pixel_t px;
			px = '{last: s_tlast, alpha: s_tdata[63:48], blue: s_tdata[47:32],
				green: s_tdata[31:16], red: s_tdata[15:0]};
			expected_pixels.push_back(predict_balanced(px));
		end
		if (arst_n && m_tvalid && m_tready) begin
			pixel_t got, want;
			got = '{last: m_tlast, alpha: m_tdata[63:48], blue: m_tdata[47:32],
				green: m_tdata[31:16], red: m_tdata[15:0]};
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected output word %h last %b", $time,
					m_tdata, m_tlast);
				any_failure = 1'b1;
			end else begin
				want = expected_pixels.pop_front();
				if (got.red != want.red) begin
					$display("%0t: red expected %h actual %h", $time, want.red, got.red);
					any_failure = 1'b1;
				end
				if (got.green != want.green) begin
					$display("%0t: green expected %h actual %h", $time,
						want.green, got.green);
					any_failure = 1'b1;
				end
				if (got.blue != want.blue) begin
					$display("%0t: blue expected %h actual %h", $time,
						want.blue, got.blue);
					any_failure = 1'b1;
				end
				if (got.alpha != want.alpha) begin
					$display("%0t: alpha expected %h actual %h", $time,
						want.alpha, got.alpha);
					any_failure = 1'b1;
				end
				if (got.last != want.last) begin
					$display("%0t: last expected %b actual %b", $time,
						want.last, got.last);
					any_failure = 1'b1;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legitimate run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		m_tready = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
		word_taken = 1'b0; cycle_count = 0; any_failure = 1'b0;
		red_corr = '0; green_corr = '0; blue_corr = '0; keep_light = 1'b0;
		sender_idle_pct = 26; receiver_idle_pct = 55;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed phase at reset values first, then strong corrections.
		for (int pass = 0; pass < 2; pass++) begin
			add_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
			add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
			add_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h5555, 1'b0);
			add_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 1'b1);
			add_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b0);
			add_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
			// Lightness sitting on the lower and upper ramp centres.
			add_pixel(16'd21823, 16'd21824, 16'd21823, 16'h1234, 1'b0);
			add_pixel(16'd43712, 16'd43713, 16'd43712, 16'h4321, 1'b1);
			add_pixel(16'd5000, 16'd60000, 16'd30000, 16'hFFFE, 1'b0);
			add_pixel(16'd65000, 16'd100, 16'd20000, 16'h7FFF, 1'b1);
			drain();
			if (pass == 0) begin
				write_reg(CFG_RED, {16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(CFG_GREEN, {16'h8000, 16'h7FFF, 16'h8000});
				write_reg(CFG_BLUE, {16'h7FFF, 16'h7FFF, 16'h8000});
				write_reg(CFG_KEEP, 48'd1);
			end
		end

		// Random phases through several register settings and idle profiles.
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				sender_idle_pct = 55; receiver_idle_pct = 26;
			end else if (phase == 4) begin
				sender_idle_pct = 0; receiver_idle_pct = 0;
			end
			case (phase)
				0: begin
					write_reg(CFG_RED, 48'h0);
					write_reg(CFG_GREEN, 48'h0);
					write_reg(CFG_BLUE, 48'h0);
					write_reg(CFG_KEEP, 48'd1);
				end
				1: begin
					write_reg(CFG_RED, {3{16'h7FFF}});
					write_reg(CFG_GREEN, {3{16'h7FFF}});
					write_reg(CFG_BLUE, {3{16'h7FFF}});
					write_reg(CFG_KEEP, 48'd0);
				end
				2: begin
					write_reg(CFG_RED, {3{16'h8000}});
					write_reg(CFG_GREEN, {3{16'h8000}});
					write_reg(CFG_BLUE, {3{16'h8000}});
					write_reg(CFG_KEEP, 48'd1);
				end
				default: begin
					write_reg(CFG_RED, {rand_corr(), rand_corr(), rand_corr()});
					write_reg(CFG_GREEN, {rand_corr(), rand_corr(), rand_corr()});
					write_reg(CFG_BLUE, {rand_corr(), rand_corr(), rand_corr()});
					write_reg(CFG_KEEP, 48'($urandom_range(1)) | 48'hFFFF_FFFF_FFFE);
				end
			endcase
			add_random_pixels(130);
			drain();
		end

		if (!any_failure) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tcb_pkg.sv
hdl/tcb_balance.sv
hdl/tcb_restore.sv
hdl/tcb_divider.sv
hdl/tonal_color_balance.sv
dv/tb_top.sv
